>>> design/sks_pkg.sv
// sks_pkg: shared types and constants for the sorted key set.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
`default_nettype none

package sks_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int ENTRIES_W    = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_DUP      = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	// What every cell does on the next clock edge.
	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_ROTATE = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic                     capture;  // latch compare flags against key
		logic signed [KEY_W-1:0]  key;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> design/sks_req_if.sv
// sks_req_if: request channel of the sorted key set (operation, key).
// Depends on sks_pkg.
`default_nettype none

interface sks_req_if;
	logic                             valid;
	logic                             ready;
	sks_pkg::op_t                     operation;
	logic signed [sks_pkg::KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

>>> design/sks_rsp_if.sv
// sks_rsp_if: result channel of the sorted key set (status, key_out, entries, last).
// Depends on sks_pkg.
`default_nettype none

interface sks_rsp_if;
	logic                                 valid;
	logic                                 ready;
	sks_pkg::status_t                     status;
	logic signed [sks_pkg::KEY_W-1:0]     key_out;
	logic        [sks_pkg::ENTRIES_W-1:0] entries;
	logic                                 last;

	modport source (output valid, output status, output key_out, output entries,
		output last, input ready);
	modport sink   (input valid, input status, input key_out, input entries,
		input last, output ready);
endinterface

`default_nettype wire

>>> design/sks_cell.sv
// sks_cell: one slot of the ordered key chain; holds a key and its compare flags.
// Depends on sks_pkg. Instantiated CAPACITY times by sorted_key_set.
`default_nettype none

module sks_cell #(
	parameter  int CAPACITY = sks_pkg::CAPACITY_DEF,
	parameter  int INDEX    = 0,
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic                              clk,
	input  wire sks_pkg::cell_cmd_t                cmd,
	input  wire logic             [CNT_W-1:0]      count,
	input  wire logic signed      [sks_pkg::KEY_W-1:0] left_key,
	input  wire logic                              left_ge,
	input  wire logic signed      [sks_pkg::KEY_W-1:0] right_key,
	input  wire logic signed      [sks_pkg::KEY_W-1:0] head_key,
	output logic signed           [sks_pkg::KEY_W-1:0] key,
	output logic                                   ge,
	output logic                                   eq
);

	localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(INDEX + 1);

	logic signed [sks_pkg::KEY_W-1:0] key_q;
	logic                             ge_q;
	logic                             eq_q;
	logic                             occupied;

	assign occupied = MY_IDX < count;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ge_q <= occupied && !(key_q < cmd.key);
			eq_q <= occupied && (key_q == cmd.key);
		end
		case (cmd.mode)
			sks_pkg::MODE_INSERT: begin
				// keys at or above the new one move up one slot
				if (left_ge) begin
					key_q <= left_key;
				end else if (ge_q || MY_IDX == count) begin
					key_q <= cmd.key;
				end
			end
			sks_pkg::MODE_DELETE: begin
				if (ge_q) begin
					key_q <= right_key;
				end
			end
			sks_pkg::MODE_ROTATE: begin
				// ring over the occupied slots: the head wraps to the tail
				key_q <= (NEXT_IDX == count) ? head_key : right_key;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign key = key_q;
	assign ge  = ge_q;
	assign eq  = eq_q;

endmodule

`default_nettype wire

>>> design/sorted_key_set.sv
// sorted_key_set: bounded ordered set of distinct signed keys in a chain of cells.
// Depends on sks_pkg, sks_req_if, sks_rsp_if and sks_cell.
//
//   channel | modport | fields                           | moves
//   req     | sink    | operation, key                   | one request per operation
//   rsp     | source  | status, key_out, entries, last   | 1 result, or 1 per key for list
//
// Insert, delete and lookup: the accept edge latches the compare flags in every cell;
// once the result slot is free, the apply state updates the chain and loads the result.
// List passes the apply state, then emits the keys from the head as the chain rotates.
// One request at a time; req.ready is high only when idle, even if a result waits.
// A stalled result holds the chain. Reset clears the control state but not the cell keys.
`default_nettype none

module sorted_key_set #(
	parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sks_req_if.sink   req,
	sks_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_APPLY = 3'b010,
		ST_LIST  = 3'b100
	} state_t;

	state_t                           state_q, state_d;
	logic [CNT_W-1:0]                 count_q, count_d;
	logic [CNT_W-1:0]                 list_idx_q, list_idx_d;
	sks_pkg::op_t                     op_q;
	logic signed [sks_pkg::KEY_W-1:0] key_q;

	logic                                 rsp_valid_q;
	sks_pkg::status_t                     status_q;
	logic signed [sks_pkg::KEY_W-1:0]     key_out_q;
	logic        [sks_pkg::ENTRIES_W-1:0] entries_q;
	logic                                 last_q;

	logic                                 emit;
	sks_pkg::status_t                     res_status;
	logic signed [sks_pkg::KEY_W-1:0]     res_key;
	logic        [sks_pkg::ENTRIES_W-1:0] res_entries;
	logic                                 res_last;

	sks_pkg::cell_cmd_t               cmd;
	logic                             accept;
	logic                             slot_free;
	logic                             found;

	logic signed [sks_pkg::KEY_W-1:0] cell_key [CAPACITY];
	logic        [CAPACITY-1:0]       cell_ge;
	logic        [CAPACITY-1:0]       cell_eq;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [sks_pkg::KEY_W-1:0] left_key;
			logic                             left_ge;
			logic signed [sks_pkg::KEY_W-1:0] right_key;
			if (gi == 0) begin : g_first
				assign left_key = cell_key[gi];
				assign left_ge  = 1'b0;
			end else begin : g_mid
				assign left_key = cell_key[gi-1];
				assign left_ge  = cell_ge[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_key = cell_key[gi];
			end else begin : g_inner
				assign right_key = cell_key[gi+1];
			end
			sks_cell #(
				.CAPACITY (CAPACITY),
				.INDEX    (gi)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.count     (count_q),
				.left_key  (left_key),
				.left_ge   (left_ge),
				.right_key (right_key),
				.head_key  (cell_key[0]),
				.key       (cell_key[gi]),
				.ge        (cell_ge[gi]),
				.eq        (cell_eq[gi])
			);
		end
	endgenerate

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign found     = |cell_eq;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		list_idx_d  = list_idx_q;
		cmd.mode    = sks_pkg::MODE_HOLD;
		cmd.capture = accept;
		cmd.key     = accept ? req.key : key_q;
		emit        = 1'b0;
		res_status  = sks_pkg::STAT_OK;
		res_key     = key_q;
		res_last    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (slot_free) begin
					case (op_q)
						sks_pkg::OP_INSERT: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (found) begin
								res_status = sks_pkg::STAT_DUP;
							end else if (count_q == FULL_CNT) begin
								res_status = sks_pkg::STAT_FULL;
							end else begin
								cmd.mode = sks_pkg::MODE_INSERT;
								count_d  = count_q + ONE;
							end
						end
						sks_pkg::OP_LIST: begin
							if (count_q == '0) begin
								emit       = 1'b1;
								res_status = sks_pkg::STAT_EMPTY;
								res_key    = '0;
								state_d    = ST_IDLE;
							end else begin
								list_idx_d = '0;
								state_d    = ST_LIST;
							end
						end
						default: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (count_q == '0) begin
								res_status = sks_pkg::STAT_EMPTY;
							end else if (!found) begin
								res_status = sks_pkg::STAT_NOTFOUND;
							end else if (op_q == sks_pkg::OP_DELETE) begin
								cmd.mode = sks_pkg::MODE_DELETE;
								count_d  = count_q - ONE;
							end
						end
					endcase
				end
			end
			ST_LIST: begin
				if (slot_free) begin
					emit       = 1'b1;
					res_key    = cell_key[0];
					res_last   = (list_idx_q + ONE) == count_q;
					cmd.mode   = sks_pkg::MODE_ROTATE;
					list_idx_d = list_idx_q + ONE;
					if (res_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_entries = sks_pkg::ENTRIES_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			list_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			list_idx_q <= list_idx_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.key;
		end
		if (emit) begin
			status_q  <= res_status;
			key_out_q <= res_key;
			entries_q <= res_entries;
			last_q    <= res_last;
		end
	end

	assign req.ready   = state_q == ST_IDLE;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.key_out = key_out_q;
	assign rsp.entries = entries_q;
	assign rsp.last    = last_q;

endmodule

`default_nettype wire

>>> design/sks_checker.sv
// sks_checker: port-level assertions for sorted_key_set, bound to the top level.
// Depends on sks_pkg and sorted_key_set.
`default_nettype none

module sks_checker #(
	parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 req_valid,
	input wire logic                                 req_ready,
	input wire logic                                 rsp_valid,
	input wire logic                                 rsp_ready,
	input wire sks_pkg::status_t                     rsp_status,
	input wire logic signed [sks_pkg::KEY_W-1:0]     rsp_key_out,
	input wire logic        [sks_pkg::ENTRIES_W-1:0] rsp_entries,
	input wire logic                                 rsp_last
);

	localparam int CAP_W = $clog2(CAPACITY + 1) + 1;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_key_out) && $stable(rsp_entries) && $stable(rsp_last))
		else $error("stalled result changed");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in progress");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == sks_pkg::STAT_EMPTY |-> rsp_entries == '0 && rsp_last)
		else $error("empty result with entries or without last");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != sks_pkg::STAT_OK |-> rsp_last)
		else $error("rejected request gave more than one result");

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> CAP_W'(rsp_entries) <= CAP_W'(CAPACITY))
		else $error("entries above capacity");

endmodule

bind sorted_key_set sks_checker #(
	.CAPACITY (CAPACITY)
) u_sks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_key_out (rsp.key_out),
	.rsp_entries (rsp.entries),
	.rsp_last    (rsp.last)
);

`default_nettype wire

>>> dv/sorted_key_set_checker.sv
// sorted_key_set_checker: watches the request and result channels, keeps its own ordered
// key set and compares every result with the predicted one. Depends on sks_pkg,
// sks_req_if and sks_rsp_if.
`default_nettype none

module sorted_key_set_checker #(
	parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sks_req_if        req,
	sks_rsp_if        rsp,
	output int        failures,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [sks_pkg::KEY_W-1:0] key_t;

	typedef struct {
		sks_pkg::status_t                status;
		key_t                            key_out;
		logic [sks_pkg::ENTRIES_W-1:0]   entries;
		logic                            last;
	} key_result_t;

	key_t        stored_keys[$];     // ascending
	key_result_t awaited_results[$];

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	function automatic void queue_result(sks_pkg::status_t st, key_t k, logic fin);
		key_result_t r;
		r.status  = st;
		r.key_out = k;
		r.entries = sks_pkg::ENTRIES_W'(stored_keys.size());
		r.last    = fin;
		awaited_results.push_back(r);
	endfunction

	function automatic int slot_of(key_t k);
		foreach (stored_keys[i])
			if (stored_keys[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void apply_request(sks_pkg::op_t op, key_t k);
		int idx;
		int pos;
		idx = slot_of(k);
		case (op)
			sks_pkg::OP_LIST: begin
				if (stored_keys.size() == 0)
					queue_result(sks_pkg::STAT_EMPTY, '0, 1'b1);
				else
					foreach (stored_keys[i])
						queue_result(sks_pkg::STAT_OK, stored_keys[i],
							i == stored_keys.size() - 1);
			end
			sks_pkg::OP_INSERT: begin
				// duplicate wins over full
				if (idx >= 0) begin
					queue_result(sks_pkg::STAT_DUP, k, 1'b1);
				end else if (stored_keys.size() >= CAPACITY) begin
					queue_result(sks_pkg::STAT_FULL, k, 1'b1);
				end else begin
					pos = 0;
					while (pos < stored_keys.size() && stored_keys[pos] < k)
						pos++;
					stored_keys.insert(pos, k);
					queue_result(sks_pkg::STAT_OK, k, 1'b1);
				end
			end
			default: begin
				if (stored_keys.size() == 0) begin
					queue_result(sks_pkg::STAT_EMPTY, k, 1'b1);
				end else if (idx < 0) begin
					queue_result(sks_pkg::STAT_NOTFOUND, k, 1'b1);
				end else begin
					if (op == sks_pkg::OP_DELETE)
						stored_keys.delete(idx);
					queue_result(sks_pkg::STAT_OK, k, 1'b1);
				end
			end
		endcase
	endfunction

	function automatic void compare_result();
		key_result_t want;
		if (awaited_results.size() == 0) begin
			$error("unexpected result: status %0d key_out %0d entries %0d last %0b",
				rsp.status, rsp.key_out, rsp.entries, rsp.last);
			failures++;
			return;
		end
		want = awaited_results.pop_front();
		if (rsp.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, rsp.status);
			failures++;
		end
		if (rsp.key_out !== want.key_out) begin
			$error("key_out: expected %0d, got %0d", want.key_out, rsp.key_out);
			failures++;
		end
		if (rsp.entries !== want.entries) begin
			$error("entries: expected %0d, got %0d", want.entries, rsp.entries);
			failures++;
		end
		if (rsp.last !== want.last) begin
			$error("last: expected %0b, got %0b", want.last, rsp.last);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				apply_request(req.operation, req.key);
			if (rsp.valid && rsp.ready)
				compare_result();
			outstanding = awaited_results.size();
		end
	end

endmodule

`default_nettype wire

>>> dv/sorted_key_set_test.sv
// sorted_key_set_test: drives requests into the sorted key set with random gaps and
// result stalls, and gives the verdict. Depends on sks_pkg, the two channel interfaces,
// sorted_key_set and sorted_key_set_checker.
`default_nettype none

module sorted_key_set_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP             = sks_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT      = 2000;
	localparam int RANDOM_REQUESTS = 93;
	localparam int POOL_SIZE       = 24;

	localparam logic signed [sks_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [sks_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   outstanding;
	int   quiet_cycles = 0;
	bit   calm = 1'b0;       // no gaps or stalls while set

	logic signed [sks_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

	sks_req_if req();
	sks_rsp_if rsp();

	sorted_key_set #(.CAPACITY(CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sorted_key_set_checker #(.CAPACITY(CAP)) set_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic signed [sks_pkg::KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_request(sks_pkg::op_t op, logic signed [sks_pkg::KEY_W-1:0] k);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.key       <= k;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// result side: optional stall on each result, then accept it
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				do @(posedge clk); while (!rsp.valid);
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int           sent;
		int           phase;
		int           phase_len;
		int           r;
		bit           grow;
		sks_pkg::op_t op;

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = sks_pkg::OP_INSERT;
		req.key       = '0;

		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = '0;
		key_pool[3] = -1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = (i % 2 == 0) ? $signed($urandom_range(0, 40)) - 20 : $urandom;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty store on every operation but insert
		send_request(sks_pkg::OP_LIST, $urandom);
		send_request(sks_pkg::OP_LOOKUP, 5);
		send_request(sks_pkg::OP_DELETE, KEY_MIN);
		// insert at first, tail, head and middle, then a duplicate
		send_request(sks_pkg::OP_INSERT, 0);
		send_request(sks_pkg::OP_INSERT, KEY_MAX);
		send_request(sks_pkg::OP_INSERT, KEY_MIN);
		send_request(sks_pkg::OP_INSERT, -1);
		send_request(sks_pkg::OP_INSERT, 0);
		send_request(sks_pkg::OP_LIST, -1);
		send_request(sks_pkg::OP_LOOKUP, KEY_MAX);
		send_request(sks_pkg::OP_LOOKUP, 1);
		send_request(sks_pkg::OP_DELETE, 7);
		send_request(sks_pkg::OP_DELETE, 0);
		send_request(sks_pkg::OP_DELETE, KEY_MIN);
		send_request(sks_pkg::OP_DELETE, KEY_MAX);
		send_request(sks_pkg::OP_LIST, $urandom);
		send_request(sks_pkg::OP_DELETE, -1);

		// alternate fill and drain phases; the first fill phase is longer than the others
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_REQUESTS) begin
			phase_len = (phase == 0) ? 30 : $urandom_range(10, 25);
			grow      = (phase % 2 == 0);
			calm      = (phase % 4 == 3);
			for (int j = 0; j < phase_len && sent < RANDOM_REQUESTS; j++) begin
				r = $urandom_range(0, 99);
				if (grow)
					op = (r < 75) ? sks_pkg::OP_INSERT : (r < 83) ? sks_pkg::OP_LOOKUP :
						(r < 91) ? sks_pkg::OP_DELETE : sks_pkg::OP_LIST;
				else
					op = (r < 15) ? sks_pkg::OP_INSERT : (r < 30) ? sks_pkg::OP_LOOKUP :
						(r < 85) ? sks_pkg::OP_DELETE : sks_pkg::OP_LIST;
				send_request(op, (op == sks_pkg::OP_LIST) ? $urandom : pick_key());
				sent++;
			end
			phase++;
		end
		calm = 1'b0;
		req.valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> sorted_key_set.f
design/sks_pkg.sv
design/sks_req_if.sv
design/sks_rsp_if.sv
design/sks_cell.sv
design/sorted_key_set.sv
design/sks_checker.sv
dv/sorted_key_set_checker.sv
dv/sorted_key_set_test.sv
